// ----- hdl/fpas_pkg.sv -----
// package for the fp32 add/subtract unit: field widths and constants
// no dependencies
`default_nettype none
package fpas_pkg;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned EXP_W  = 8;
    localparam int unsigned FRAC_W = 23;
    localparam int unsigned MAG_W  = 25;
    localparam logic [7:0]  EXP_MAX_NORMAL = 8'd254;
    localparam logic [4:0]  SHIFT_LIMIT    = 5'd25;
    localparam logic [30:0] INF_BITS       = 31'h7f80_0000;

    typedef struct packed {
        logic                sign;
        logic [EXP_W-1:0]    exp;
        logic [MAG_W-1:0]    mag;
    } t_sum;
endpackage
`default_nettype wire

// ----- hdl/fpas_align_add.sv -----
// swap, align and magnitude add/subtract for the fp32 add/subtract unit
// depends on fpas_pkg
`default_nettype none
module fpas_align_add (
    input  wire logic [31:0]   i_a,
    input  wire logic [31:0]   i_b,
    input  wire logic          i_add,
    output fpas_pkg::t_sum     o_sum
);
    import fpas_pkg::*;

    logic        sa, sb, a_big;
    logic [7:0]  ea, eb, big_e, small_e, d;
    logic [23:0] ma, mb, big_m, small_m, aligned;

    always_comb begin
        sa = i_a[31];
        sb = i_b[31] ^ ~i_add;
        ea = i_a[30:23];
        eb = i_b[30:23];
        ma = {1'b1, i_a[22:0]};
        mb = {1'b1, i_b[22:0]};
        a_big = (ea > eb) || (ea == eb && ma >= mb);
        big_m   = a_big ? ma : mb;
        small_m = a_big ? mb : ma;
        big_e   = a_big ? ea : eb;
        small_e = a_big ? eb : ea;
        d = big_e - small_e;
        aligned = (d >= {3'd0, SHIFT_LIMIT}) ? 24'd0 : (small_m >> d[4:0]);
        o_sum.sign = a_big ? sa : sb;
        o_sum.exp  = big_e;
        o_sum.mag  = (sa == sb) ? ({1'b0, big_m} + {1'b0, aligned})
                                : ({1'b0, big_m} - {1'b0, aligned});
    end
endmodule
`default_nettype wire

// ----- hdl/fpas_normalize.sv -----
// leading-one search, renormalize, overflow and underflow handling
// depends on fpas_pkg
`default_nettype none
module fpas_normalize (
    input  wire fpas_pkg::t_sum i_sum,
    output logic [31:0]        o_bits,
    output logic               o_ovf
);
    import fpas_pkg::*;

    logic [4:0]  p;
    logic        found;
    logic [24:0] norm;
    logic signed [9:0] e;

    always_comb begin
        p = 5'd0;
        found = 1'b0;
        for (int i = 0; i < MAG_W; i++) begin
            if (i_sum.mag[i]) begin
                p = 5'(i);
                found = 1'b1;
            end
        end
        // adj = p - 23, only p = 24 shifts right
        norm = (p == 5'd24) ? (i_sum.mag >> 1) : (i_sum.mag << (5'd23 - p));
        e = $signed({2'b00, i_sum.exp}) + $signed({5'b0, p}) - 10'sd23;
        o_ovf = 1'b0;
        if (!found) begin
            o_bits = '0;
        end else if (e > $signed({2'b00, EXP_MAX_NORMAL})) begin
            o_bits = {i_sum.sign, INF_BITS};
            o_ovf  = 1'b1;
        end else if (e <= 10'sd0) begin
            o_bits = {i_sum.sign, 31'd0};
        end else begin
            o_bits = {i_sum.sign, e[7:0], norm[22:0]};
        end
    end
endmodule
`default_nettype wire

// ----- hdl/fp32_add_subtract_unit.sv -----
// fp32 add/subtract unit: truncating single-precision adder, one operand pair per cycle
// path: the start beat reaches the o_valid strobe through the input registers, then the result registers
// throughput: one beat per cycle; busy is never raised, the receiver cannot stall
// reset: synchronous active-low i_rst_n clears the valid flags only
// depends on fpas_pkg, fpas_align_add, fpas_normalize
`default_nettype none
module fp32_add_subtract_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_operand_a,
    input  wire logic [31:0] i_operand_b,
    input  wire logic        i_mode,
    output logic             o_valid,
    output logic [31:0]      o_result_bits,
    output logic             o_overflow
);
    import fpas_pkg::*;

    logic        r_in_v, r_out_v;
    logic [31:0] r_a, r_b, r_res;
    logic        r_mode, r_ovf;
    t_sum        sum;
    logic [31:0] n_res;
    logic        n_ovf;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_in_v  <= start;
            r_out_v <= r_in_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= i_operand_a;
        r_b    <= i_operand_b;
        r_mode <= i_mode;
        r_res  <= n_res;
        r_ovf  <= n_ovf;
    end

    fpas_align_add u_add (.i_a(r_a), .i_b(r_b), .i_add(r_mode), .o_sum(sum));
    fpas_normalize u_norm (.i_sum(sum), .o_bits(n_res), .o_ovf(n_ovf));

    assign o_valid       = r_out_v;
    assign o_result_bits = r_res;
    assign o_overflow    = r_ovf;

    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> ##1 o_valid) else $error("result strobe missing");
    a_ovf_inf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> (o_result_bits[30:0] == INF_BITS))
        else $error("overflow without infinity");
    a_nz_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_overflow) |-> (o_result_bits[30:23] != 8'hff))
        else $error("max exponent without overflow");
endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// testbench for fp32_add_subtract_unit: queued driver, strobe monitor, built-in sum predictor
// depends on fpas_pkg and the unit rtl
`default_nettype none
module tb_top;
    import fpas_pkg::*;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic        mode;
    } t_pair;

    typedef struct packed {
        logic [31:0] bits;
        logic        ovf;
    } t_sum_out;

    localparam logic MODE_SUB = 1'b0;
    localparam logic MODE_ADD = 1'b1;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_operand_a;
    logic [31:0] i_operand_b;
    logic        i_mode;
    logic        o_valid;
    logic [31:0] o_result_bits;
    logic        o_overflow;

    t_pair    pair_q[$];
    t_sum_out sum_q[$];
    int       errors;
    int       idle_pct;
    bit       hold_send;

    fp32_add_subtract_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_operand_a(i_operand_a), .i_operand_b(i_operand_b), .i_mode(i_mode),
        .o_valid(o_valid), .o_result_bits(o_result_bits), .o_overflow(o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_sum_out fp_sum(t_pair p);
        logic        sa, sb, sgn;
        logic [7:0]  ea, eb, big_e, small_e, d;
        logic [23:0] ma, mb, big_m, small_m, aligned;
        logic [24:0] mag;
        logic [31:0] norm;
        int          lead, shift, e;
        t_sum_out    r;
        sa = p.a[31];
        sb = p.b[31] ^ (p.mode == MODE_SUB);
        ea = p.a[30:23];
        eb = p.b[30:23];
        ma = {1'b1, p.a[22:0]};
        mb = {1'b1, p.b[22:0]};
        if (ea > eb || (ea == eb && ma >= mb)) begin
            big_m = ma; big_e = ea; small_m = mb; small_e = eb; sgn = sa;
        end else begin
            big_m = mb; big_e = eb; small_m = ma; small_e = ea; sgn = sb;
        end
        d = big_e - small_e;
        aligned = (d >= 8'd25) ? 24'd0 : (small_m >> d);
        mag = (sa == sb) ? {1'b0, big_m} + aligned : {1'b0, big_m} - aligned;
        r.ovf = 1'b0;
        if (mag == 25'd0) begin
            r.bits = 32'd0;
        end else begin
            lead = 0;
            for (int i = 0; i < 25; i++) if (mag[i]) lead = i;
            shift = lead - 23;
            e = int'(big_e) + shift;
            norm = (shift >= 0) ? (32'(mag) >> shift) : (32'(mag) << (-shift));
            if (e > 254) begin
                r.bits = {sgn, 31'h7f80_0000};
                r.ovf  = 1'b1;
            end else if (e <= 0) begin
                r.bits = {sgn, 31'd0};
            end else begin
                r.bits = {sgn, e[7:0], norm[22:0]};
            end
        end
        return r;
    endfunction

    // driver: one beat per accepted start, idling per phase
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && busy)) begin
            if (pair_q.size() > 0 && !hold_send && $urandom_range(99) >= idle_pct) begin
                t_pair p;
                p = pair_q.pop_front();
                start       <= 1'b1;
                i_operand_a <= p.a;
                i_operand_b <= p.b;
                i_mode      <= p.mode;
                sum_q.push_back(fp_sum(p));
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (sum_q.size() == 0) begin
                $display("%0t: unexpected result %h ovf %b", $time, o_result_bits, o_overflow);
                errors++;
            end else begin
                t_sum_out x;
                x = sum_q.pop_front();
                if (o_result_bits !== x.bits) begin
                    $display("%0t: result_bits expected %h actual %h", $time, x.bits,
                             o_result_bits);
                    errors++;
                end
                if (o_overflow !== x.ovf) begin
                    $display("%0t: overflow expected %b actual %b", $time, x.ovf, o_overflow);
                    errors++;
                end
            end
        end
    end

    task automatic add_pair(logic [31:0] a, logic [31:0] b, logic m);
        pair_q.push_back('{a: a, b: b, mode: m});
    endtask

    function automatic logic [31:0] rand_word();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(5))
            0: w[30:23] = 8'd255 - 8'($urandom_range(3));
            1: w[30:23] = 8'($urandom_range(3));
            default: ;
        endcase
        return w;
    endfunction

    task automatic drain();
        wait (pair_q.size() == 0 && sum_q.size() == 0);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] a;
        errors = 0; idle_pct = 0; hold_send = 1'b0;
        start = 1'b0; i_operand_a = '0; i_operand_b = '0; i_mode = MODE_ADD;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: extremes, both modes, ties, cancellation, overflow, underflow
        add_pair(32'h0000_0000, 32'h0000_0000, MODE_ADD);
        add_pair(32'hffff_ffff, 32'hffff_ffff, MODE_ADD);
        add_pair(32'hffff_ffff, 32'h0000_0000, MODE_SUB);
        add_pair(32'h3f80_0000, 32'h3f80_0000, MODE_SUB);
        add_pair(32'hbf80_0000, 32'h3f80_0000, MODE_ADD);
        add_pair(32'h3f80_0000, 32'h3f80_0000, MODE_ADD);
        add_pair(32'h7f7f_ffff, 32'h7f7f_ffff, MODE_ADD);
        add_pair(32'hff7f_ffff, 32'h7f7f_ffff, MODE_SUB);
        add_pair(32'h7f80_0000, 32'h7fc0_0000, MODE_ADD);
        add_pair(32'h0080_0000, 32'h0080_0001, MODE_SUB);
        add_pair(32'h0000_0001, 32'h0000_0000, MODE_SUB);
        add_pair(32'h3f80_0000, 32'h3380_0000, MODE_ADD);
        add_pair(32'h3f80_0000, 32'h3300_0000, MODE_ADD);
        add_pair(32'h3f80_0000, 32'h3f7f_ffff, MODE_SUB);
        add_pair(32'h4000_0000, 32'hbf80_0000, MODE_ADD);
        add_pair(32'h5555_5555, 32'haaaa_aaaa, MODE_SUB);
        drain();
        // hold the driver while ten random pairs are queued, then release
        hold_send = 1'b1;
        for (int i = 0; i < 10; i++) add_pair(rand_word(), rand_word(), 1'($urandom_range(1)));
        hold_send = 1'b0;
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 70 : (ph == 3) ? 8 : 0;
            for (int i = 0; i < 110; i++) begin
                a = rand_word();
                // near-equal operands exercise cancellation and renormalization
                if ($urandom_range(3) == 0)
                    add_pair(a, a ^ 32'($urandom_range(15)), 1'($urandom_range(1)));
                else
                    add_pair(a, rand_word(), 1'($urandom_range(1)));
            end
            drain();
        end
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire

// ----- files.f -----
hdl/fpas_pkg.sv
hdl/fpas_align_add.sv
hdl/fpas_normalize.sv
hdl/fp32_add_subtract_unit.sv
dv/tb_top.sv
